/* rtl/gbp_pkg.sv */
// Shared types and constants of the gshare branch predictor.
package gbp_pkg;

   localparam logic [2:0] CMD_LOOKUP        = 3'd0;
   localparam logic [2:0] CMD_UNCONDITIONAL = 3'd1;
   localparam logic [2:0] CMD_UPDATE        = 3'd2;
   localparam logic [2:0] CMD_SQUASH        = 3'd3;
   localparam logic [2:0] CMD_BTB_MISS      = 3'd4;

   localparam logic CSR_ADDRESS_SHIFT = 1'b0;
   localparam logic CSR_COUNTER_BITS  = 1'b1;

   localparam int SNAP_W = 12;

   typedef struct packed {
      logic [2:0] address_shift;
      logic [3:0] counter_bits;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

endpackage

/* rtl/gshare_branch_predictor.sv */
// Top level of the gshare branch predictor: configuration registers and wiring.
//
//   Channel  Direction  Words
//   req      in         one command with branch address, outcome and saved history
//   rsp      out        one prediction and history snapshot per command
//   csr      in         writes of address_shift (index 0) and counter_bits (index 1)
//
// The table read is issued when the word is accepted; in the execute state the
// counter is read, and an update with history_valid set writes it back modified.
// After reset a clearing pass writes zero to every counter of the table, one per
// cycle, and no word is accepted until that pass is done. A result held in the
// output register while rsp_tready is low delays the write-back, and req_tready
// stays low until it moves on.
module gshare_branch_predictor #(
   parameter int TABLE_SIZE    = 4096,
   parameter int COUNTER_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // branch_addr[63:0], taken[64], squashed[65], saved_history[77:66],
   // history_valid[78], zero[79]
   input  logic [79:0] req_tdata,
   // command[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // prediction[0], history_snapshot[12:1], zero[15:13]
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_SIZE);

   gbp_pkg::cfg_type         cfg_ff, cfg_in;
   logic                     ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]         ram_wr_addr, ram_rd_addr;
   logic [COUNTER_WIDTH-1:0] ram_wr_data, ram_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            gbp_pkg::CSR_ADDRESS_SHIFT: cfg_in.address_shift = csr_wdata[2:0];
            gbp_pkg::CSR_COUNTER_BITS:  cfg_in.counter_bits  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.address_shift <= 3'd2;
         cfg_ff.counter_bits  <= 4'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gbp_ctrl #(
      .IDX_W (IDX_W),
      .CNT_W (COUNTER_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   gbp_counter_ram #(
      .ADDR_W (IDX_W),
      .DATA_W (COUNTER_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

/* rtl/gbp_counter_ram.sv */
// Counter table memory with one write port and one registered read port.
module gbp_counter_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [(1 << ADDR_W)];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gbp_ctrl.sv */
// Sequencer of the predictor: clearing pass, table read-modify-write and history.
module gbp_ctrl #(
   parameter int IDX_W = 12,
   parameter int CNT_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gbp_pkg::cfg_type        cfg,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [79:0]             req_tdata,
   input  logic [2:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [15:0]             rsp_tdata,
   output logic                    ram_wr_en,
   output logic [IDX_W-1:0]        ram_wr_addr,
   output logic [CNT_W-1:0]        ram_wr_data,
   output logic                    ram_rd_en,
   output logic [IDX_W-1:0]        ram_rd_addr,
   input  logic [CNT_W-1:0]        ram_rd_data
);

   localparam int EXT_W = (IDX_W > gbp_pkg::SNAP_W) ? IDX_W : gbp_pkg::SNAP_W;

   gbp_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] hist_ff, hist_in;
   logic [2:0]       cmd_ff;
   logic             taken_ff, squashed_ff, hvalid_ff;
   logic [11:0]      saved_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             pred_ff, pred_in;
   logic [11:0]      snap_ff, snap_in;

   logic [63:0]      addr_sh;
   logic [EXT_W-1:0] req_saved_ext;
   logic [IDX_W-1:0] req_idx;
   logic             accept;

   logic [EXT_W-1:0] saved_ext, hist_ext;
   logic [IDX_W:0]   hist_cat_pred, hist_cat_one;
   logic [EXT_W:0]   saved_cat;
   logic [3:0]       bits;
   logic [CNT_W-1:0] ones, maxv, half, cnt_new;
   logic             pred_now, can_out;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == gbp_pkg::ST_IDLE);

   assign addr_sh       = req_tdata[63:0] >> cfg.address_shift;
   assign req_saved_ext = EXT_W'(req_tdata[77:66]);

   always_comb begin
      if (req_tuser == gbp_pkg::CMD_UPDATE) begin
         req_idx = addr_sh[IDX_W-1:0] ^ req_saved_ext[IDX_W-1:0];
      end else begin
         req_idx = addr_sh[IDX_W-1:0] ^ hist_ff;
      end
   end

   assign ram_rd_en   = accept;
   assign ram_rd_addr = req_idx;

   always_comb begin
      if (cfg.counter_bits == 4'd0) begin
         bits = 4'd1;
      end else if (cfg.counter_bits > 4'(CNT_W)) begin
         bits = 4'(CNT_W);
      end else begin
         bits = cfg.counter_bits;
      end
   end

   assign ones     = '1;
   assign maxv     = ones >> (4'(CNT_W) - bits);
   assign half     = CNT_W'(1) << (bits - 4'd1);
   assign pred_now = (ram_rd_data >= half);

   always_comb begin
      cnt_new = ram_rd_data;
      if (taken_ff) begin
         if (ram_rd_data < maxv) begin
            cnt_new = ram_rd_data + CNT_W'(1);
         end
      end else if (ram_rd_data != '0) begin
         cnt_new = ram_rd_data - CNT_W'(1);
      end
   end

   assign saved_ext     = EXT_W'(saved_ff);
   assign hist_ext      = EXT_W'(hist_ff);
   assign hist_cat_pred = {hist_ff, pred_now};
   assign hist_cat_one  = {hist_ff, 1'b1};
   assign saved_cat     = {saved_ext, taken_ff};
   assign can_out       = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      hist_in      = hist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pred_in      = pred_ff;
      snap_in      = snap_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = cnt_new;
      case (state_ff)
         gbp_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + IDX_W'(1);
            if (clr_ff == '1) begin
               state_in = gbp_pkg::ST_IDLE;
            end
         end
         gbp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = gbp_pkg::ST_EXEC;
            end
         end
         gbp_pkg::ST_EXEC: begin
            if (can_out) begin
               state_in     = gbp_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               pred_in      = 1'b0;
               snap_in      = '0;
               case (cmd_ff)
                  gbp_pkg::CMD_LOOKUP: begin
                     pred_in = pred_now;
                     snap_in = hist_ext[11:0];
                     hist_in = hist_cat_pred[IDX_W-1:0];
                  end
                  gbp_pkg::CMD_UNCONDITIONAL: begin
                     pred_in = 1'b1;
                     snap_in = hist_ext[11:0];
                     hist_in = hist_cat_one[IDX_W-1:0];
                  end
                  gbp_pkg::CMD_UPDATE: begin
                     if (hvalid_ff) begin
                        ram_wr_en = 1'b1;
                        if (squashed_ff) begin
                           hist_in = saved_cat[IDX_W-1:0];
                        end
                     end
                  end
                  gbp_pkg::CMD_SQUASH: begin
                     hist_in = saved_ext[IDX_W-1:0];
                  end
                  gbp_pkg::CMD_BTB_MISS: begin
                     hist_in = hist_ff & ~IDX_W'(1);
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = gbp_pkg::ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbp_pkg::ST_CLEAR;
         clr_ff       <= '0;
         hist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hist_ff      <= hist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pred_ff <= pred_in;
      snap_ff <= snap_in;
      if (accept) begin
         cmd_ff      <= req_tuser;
         taken_ff    <= req_tdata[64];
         squashed_ff <= req_tdata[65];
         saved_ff    <= req_tdata[77:66];
         hvalid_ff   <= req_tdata[78];
         idx_ff      <= req_idx;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, snap_ff, pred_ff};

endmodule
